FILE: src/nofm_pkg.sv
// Shared constants and status codes for the orbit frame matrix block.
`default_nettype none
package nofm_pkg;

  localparam int FRAC_BITS = 30;
  // the largest normalized magnitude sits in [2^NORM_TOP, 2^(NORM_TOP+1))
  localparam int NORM_TOP = 30;

  localparam int SQ_STAGES = 16;   // two root bits per stage
  localparam int DV_STAGES = 16;   // two quotient bits per stage
  localparam int UNIT_LAT  = 4 + SQ_STAGES + 1 + DV_STAGES + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_PARALLEL = 2'd2;

endpackage
`default_nettype wire

FILE: src/nofm_unit.sv
// Pipelined unit-vector unit: normalize, sum of squares, square root, divide.
`default_nettype none
module nofm_unit import nofm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [1:0]         tag_i,
  input  logic [63:0]        mag_i [3],
  input  logic [2:0]         neg_i,
  output logic               valid_o,
  output logic [1:0]         tag_o,
  output logic signed [31:0] q_o [3]
);

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] s;
  } sqrt_st_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] q;
    logic [31:0] n;
  } div_st_t;

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  function automatic sqrt_st_t sqrt_step(sqrt_st_t x);
    sqrt_st_t    y;
    logic [35:0] r2;
    logic [35:0] tr;
    r2 = {x.rem[33:0], x.s[63:62]};
    tr = {2'b00, x.root, 2'b01};
    if (r2 >= tr) begin
      y.rem  = r2 - tr;
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = r2;
      y.root = {x.root[30:0], 1'b0};
    end
    y.s = {x.s[61:0], 2'b00};
    return y;
  endfunction

  function automatic div_st_t div_step(div_st_t x, logic [31:0] dv);
    div_st_t     y;
    logic [32:0] r2;
    r2 = {x.rem[31:0], x.n[31]};
    if (r2 >= {1'b0, dv}) begin
      y.rem = r2 - {1'b0, dv};
      y.q   = {x.q[30:0], 1'b1};
    end else begin
      y.rem = r2;
      y.q   = {x.q[30:0], 1'b0};
    end
    y.n = {x.n[30:0], 1'b0};
    return y;
  endfunction

  // sideband line: valid, tag, signs
  logic [UNIT_LAT-1:0] vld_q;
  logic [1:0]          tag_q [UNIT_LAT];
  logic [2:0]          neg_q [UNIT_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[UNIT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      neg_q[0] <= neg_i;
      for (int k = 1; k < UNIT_LAT; k++) begin
        tag_q[k] <= tag_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // stage 0: leading one of the OR equals that of the largest magnitude
  logic [63:0] m0_q [3];
  logic [5:0]  p_q;
  logic [63:0] or_all;
  logic [5:0]  p_d;

  always_comb begin
    or_all = mag_i[0] | mag_i[1] | mag_i[2];
    p_d    = '0;
    for (int k = 0; k < 64; k++) begin
      if (or_all[k]) p_d = 6'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= mag_i;
      p_q  <= p_d;
    end
  end

  // stage 1: common shift
  logic [30:0] ms_q [3];
  logic [30:0] ms_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p_q < 6'(NORM_TOP)) begin
        ms_d[i] = 31'(m0_q[i] << (6'(NORM_TOP) - p_q));
      end else begin
        ms_d[i] = 31'(m0_q[i] >> (p_q - 6'(NORM_TOP)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ms_q <= ms_d;
  end

  // stage 2: squares
  logic [61:0] sqr_q [3];
  logic [30:0] ms2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sqr_q[i] <= 62'(ms_q[i]) * 62'(ms_q[i]);
      ms2_q <= ms_q;
    end
  end

  // stage 3: sum, seeds the root pipeline
  sqrt_st_t    sq_q [SQ_STAGES+1];
  logic [30:0] mq_q [SQ_STAGES+1][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].s    <= 64'(sqr_q[0]) + 64'(sqr_q[1]) + 64'(sqr_q[2]);
      mq_q[0]      <= ms2_q;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1] <= sqrt_step(sqrt_step(sq_q[k]));
        mq_q[k+1] <= mq_q[k];
      end
    end
  end

  // numerator with half-divisor rounding, then divide
  div_st_t     dv_q [DV_STAGES+1][3];
  logic [31:0] dn_q [DV_STAGES+1];
  logic [63:0] num  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (64'(mq_q[SQ_STAGES][i]) << FRAC_BITS) + 64'(sq_q[SQ_STAGES].root >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[0][i].rem <= {1'b0, num[i][63:32]};
        dv_q[0][i].q   <= '0;
        dv_q[0][i].n   <= num[i][31:0];
      end
      dn_q[0] <= sq_q[SQ_STAGES].root;
    end
  end

  for (genvar k = 0; k < DV_STAGES; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_q[k+1][i] <= div_step(div_step(dv_q[k][i], dn_q[k]), dn_q[k]);
        end
        dn_q[k+1] <= dn_q[k];
      end
    end
  end

  // clamp to one, apply sign
  logic signed [31:0] res_q [3];
  logic [31:0]        qc    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[DV_STAGES][i].q > ONE) ? ONE : dv_q[DV_STAGES][i].q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= neg_q[UNIT_LAT-2][i] ? -$signed(qc[i]) : $signed(qc[i]);
      end
    end
  end

  assign q_o     = res_q;
  assign valid_o = vld_q[UNIT_LAT-1];
  assign tag_o   = tag_q[UNIT_LAT-1];

endmodule
`default_nettype wire

FILE: src/nominal_orbit_frame_matrix.sv
// Top level: velocity-aligned orbit frame rotation matrix, Q1.30 entries.
//
//  channel | signals                               | dir | handshake
//  --------+---------------------------------------+-----+------------------
//  in      | pos_x/y/z_i, vel_x/y/z_i (s32)        | in  | in_valid_i/in_ready_o
//  out     | m11..m33_o (s32), status_o (2b)       | out | out_valid_o/out_ready_i
//  cfg     | cfg_wdata_i = velocity_flip           | in  | cfg_we_i, no wait
//
// One word accepted per cycle while not stalled; most stages are the root
// and divider pipelines in the unit-vector units, two result bits per stage.
// Reset clears valid bits and velocity_flip only; no clearing pass.
// A stall at the output freezes the whole pipeline; in_ready_o falls with it.
`default_nettype none
module nominal_orbit_frame_matrix import nofm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] m11_o,
  output logic signed [31:0] m21_o,
  output logic signed [31:0] m31_o,
  output logic signed [31:0] m12_o,
  output logic signed [31:0] m22_o,
  output logic signed [31:0] m32_o,
  output logic signed [31:0] m13_o,
  output logic signed [31:0] m23_o,
  output logic signed [31:0] m33_o,
  output logic [1:0]         status_o
);

  localparam logic [64:0] ONE_W  = 65'd1 << FRAC_BITS;
  localparam logic [64:0] HALF_W = 65'd1 << (FRAC_BITS - 1);

  // rounded, limited a*b - c*d of Q values
  function automatic logic signed [31:0] qround(logic signed [63:0] p,
                                                logic signed [63:0] q);
    logic signed [64:0] t;
    logic [64:0]        tm;
    logic [64:0]        r;
    t  = 65'(p) - 65'(q);
    tm = t[64] ? 65'(-t) : 65'(t);
    r  = (tm + HALF_W) >> FRAC_BITS;
    if (r > ONE_W) r = ONE_W;
    return t[64] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  logic en;
  logic out_valid_q;
  logic velocity_flip_q;

  // one enable for every stage: advance unless the output word is stuck
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      velocity_flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      velocity_flip_q <= cfg_wdata_i;
    end
  end

  // stage A: negated position, optionally flipped velocity (33 bits, no wrap)
  logic signed [32:0] a_q [3];
  logic signed [32:0] b_q [3];
  logic signed [32:0] a_d [3];
  logic signed [32:0] b_d [3];
  logic               va_q, vb_q, vc_q, vd_q;

  always_comb begin
    a_d[0] = -33'(pos_x_i);
    a_d[1] = -33'(pos_y_i);
    a_d[2] = -33'(pos_z_i);
    b_d[0] = velocity_flip_q ? -33'(vel_x_i) : 33'(vel_x_i);
    b_d[1] = velocity_flip_q ? -33'(vel_y_i) : 33'(vel_y_i);
    b_d[2] = velocity_flip_q ? -33'(vel_z_i) : 33'(vel_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // stage B: cross product terms, zero checks, velocity magnitudes
  logic signed [65:0] p_q [6];
  logic               zero_q;
  logic [31:0]        vm_q [3];
  logic [2:0]         vn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= a_q[1] * b_q[2];
      p_q[1] <= a_q[2] * b_q[1];
      p_q[2] <= a_q[2] * b_q[0];
      p_q[3] <= a_q[0] * b_q[2];
      p_q[4] <= a_q[0] * b_q[1];
      p_q[5] <= a_q[1] * b_q[0];
      zero_q <= (a_q[0] == '0 && a_q[1] == '0 && a_q[2] == '0) ||
                (b_q[0] == '0 && b_q[1] == '0 && b_q[2] == '0);
      for (int i = 0; i < 3; i++) begin
        vm_q[i] <= b_q[i][32] ? 32'(-b_q[i]) : 32'(b_q[i]);
        vn_q[i] <= b_q[i][32];
      end
    end
  end

  // stage C: cross product as sign and magnitude, status
  logic [63:0]        cm_q [3];
  logic [2:0]         cn_q;
  logic [63:0]        vm2_q [3];
  logic [2:0]         vn2_q;
  logic [1:0]         stc_q;
  logic signed [66:0] cd [3];
  logic signed [66:0] cdm [3];
  logic [1:0]         stc_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd[i]  = 67'(p_q[2*i]) - 67'(p_q[2*i+1]);
      cdm[i] = cd[i][66] ? -cd[i] : cd[i];
    end
    if (zero_q) begin
      stc_d = ST_ZERO;
    end else if (p_q[0] == p_q[1] && p_q[2] == p_q[3] && p_q[4] == p_q[5]) begin
      stc_d = ST_PARALLEL;
    end else begin
      stc_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm_q[i]  <= cdm[i][63:0];
        cn_q[i]  <= cd[i][66];
        vm2_q[i] <= 64'(vm_q[i]);
      end
      vn2_q <= vn_q;
      stc_q <= stc_d;
    end
  end

  // unit velocity and unit cross vector
  logic signed [31:0] u1 [3];
  logic signed [31:0] u2 [3];
  logic               uv_valid, uc_valid;
  logic [1:0]         u_status, uc_tag;

  nofm_unit u_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .tag_i   (stc_q),
    .mag_i   (vm2_q),
    .neg_i   (vn2_q),
    .valid_o (uv_valid),
    .tag_o   (u_status),
    .q_o     (u1)
  );

  nofm_unit u_crs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .tag_i   (stc_q),
    .mag_i   (cm_q),
    .neg_i   (cn_q),
    .valid_o (uc_valid),
    .tag_o   (uc_tag),
    .q_o     (u2)
  );

  // stage D: third column products
  logic signed [63:0] w_q [6];
  logic signed [31:0] u1d_q [3];
  logic signed [31:0] u2d_q [3];
  logic [1:0]         std_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q[0] <= u1[1] * u2[2];
      w_q[1] <= u1[2] * u2[1];
      w_q[2] <= u1[2] * u2[0];
      w_q[3] <= u1[0] * u2[2];
      w_q[4] <= u1[0] * u2[1];
      w_q[5] <= u1[1] * u2[0];
      u1d_q  <= u1;
      u2d_q  <= u2;
      std_q  <= u_status;
    end
  end

  // stage E: output word; a degenerate frame gives an all-zero matrix
  logic signed [31:0] m_q [9];
  logic [1:0]         st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]   <= (std_q == ST_OK) ? u1d_q[i] : '0;
        m_q[3+i] <= (std_q == ST_OK) ? u2d_q[i] : '0;
        m_q[6+i] <= (std_q == ST_OK) ? qround(w_q[2*i], w_q[2*i+1]) : '0;
      end
      st_q <= std_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= in_valid_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= uv_valid;
      out_valid_q <= vd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign m11_o = m_q[0];
  assign m21_o = m_q[1];
  assign m31_o = m_q[2];
  assign m12_o = m_q[3];
  assign m22_o = m_q[4];
  assign m32_o = m_q[5];
  assign m13_o = m_q[6];
  assign m23_o = m_q[7];
  assign m33_o = m_q[8];
  assign status_o = st_q;

  // both unit pipelines must stay in lockstep
  a_unit_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uv_valid == uc_valid && (!uv_valid || u_status == uc_tag))
    else $error("unit pipelines out of step");

  // degenerate status words carry zeros on the diagonal and in m13, m31
  a_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (m11_o == 0 && m22_o == 0 && m33_o == 0 && m13_o == 0 && m31_o == 0))
    else $error("nonzero matrix with bad status");

  // entries m11 and m13 never exceed one in magnitude
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m11_o <= 32'sd1073741824 && m11_o >= -32'sd1073741824 &&
                     m13_o <= 32'sd1073741824 && m13_o >= -32'sd1073741824))
    else $error("matrix entry out of range");

  // a taken word with a valid word behind it is replaced next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && vd_q) |=> out_valid_o)
    else $error("pipeline dropped a word");

endmodule
`default_nettype wire
